/* rtl/core/isp_pkg.sv */
package isp_pkg;

	localparam int CMD_W       = 2;
	localparam int ADDR_IN_W   = 16;
	localparam int ENV_W       = 16;
	localparam int POS_W       = 32;
	localparam int STEP_W      = 24;
	localparam int LEN_REG_W   = 17;
	localparam int VEL_W       = 7;
	localparam int GAIN_W      = 20;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 24;
	localparam int CMP_W       = 21;
	localparam int VE_W        = VEL_W + ENV_W;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [STEP_W-1:0]    RST_STEP = 24'd65536;
	localparam logic [LEN_REG_W-1:0] RST_LEN  = 17'd65536;
	localparam logic [VEL_W-1:0]     RST_VEL  = 7'd127;
	localparam logic [GAIN_W-1:0]    RST_GAIN = 20'd92682;

	// velocity/envelope scale is 1/(127 * 2^16), rounded
	localparam int VE_DIV     = 127;
	localparam int VE_SHIFT   = 16;
	localparam int VE_HALF    = VE_DIV * (1 << (VE_SHIFT - 1));
	localparam int DIGIT_W    = 7;
	localparam int DIV_STOP   = 2 * VE_DIV;
	localparam int GAIN_SHIFT = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD    = 2'd0,
		CMD_TICK    = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP   = 2'd0,
		REG_LENGTH = 2'd1,
		REG_VEL    = 2'd2,
		REG_GAIN   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic valid;
		cmd_t kind;
	} q_head_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic cap_a;
		logic do_interp;
		logic do_vel;
		logic div_step;
		logic do_fix;
		logic do_gain;
	} lane_ctrl_t;

endpackage

/* rtl/core/isp_ram.sv */
module isp_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/isp_front.sv */
module isp_front #(
	parameter int SAMPLE_DEPTH = 65536,
	parameter int SAMPLE_BITS  = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [isp_pkg::CMD_W-1:0]             cmd,
	input  logic [isp_pkg::ADDR_IN_W-1:0]         load_address,
	input  logic signed [SAMPLE_BITS-1:0]         load_left,
	input  logic signed [SAMPLE_BITS-1:0]         load_right,
	input  logic [isp_pkg::ENV_W-1:0]             envelope,
	output isp_pkg::q_head_t                      head,
	output logic [$clog2(SAMPLE_DEPTH)-1:0]       head_addr,
	output logic signed [SAMPLE_BITS-1:0]         head_left,
	output logic signed [SAMPLE_BITS-1:0]         head_right,
	output logic [isp_pkg::ENV_W-1:0]             head_env,
	input  logic                                  pop
);

	localparam int AW    = $clog2(SAMPLE_DEPTH);
	localparam int PTR_W = $clog2(isp_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(isp_pkg::QUEUE_DEPTH + 1);

	isp_pkg::cmd_t               kind_q  [isp_pkg::QUEUE_DEPTH];
	logic [AW-1:0]               addr_q  [isp_pkg::QUEUE_DEPTH];
	logic signed [SAMPLE_BITS-1:0] left_q  [isp_pkg::QUEUE_DEPTH];
	logic signed [SAMPLE_BITS-1:0] right_q [isp_pkg::QUEUE_DEPTH];
	logic [isp_pkg::ENV_W-1:0]   env_q   [isp_pkg::QUEUE_DEPTH];

	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [isp_pkg::CMP_W-1:0] addr_ext;
	logic keep, push, do_pop;

	assign addr_ext = isp_pkg::CMP_W'(load_address);

	// out-of-range loads and the spare code are taken and dropped here
	always_comb begin
		case (cmd)
			isp_pkg::CMD_LOAD:    keep = addr_ext < isp_pkg::CMP_W'(SAMPLE_DEPTH);
			isp_pkg::CMD_TICK:    keep = 1'b1;
			isp_pkg::CMD_RESTART: keep = 1'b1;
			default:              keep = 1'b0;
		endcase
	end

	assign in_stall = count_q == CNT_W'(isp_pkg::QUEUE_DEPTH);
	assign push     = in_valid && !in_stall && keep;
	assign do_pop   = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			kind_q[wr_ptr_q]  <= isp_pkg::cmd_t'(cmd);
			addr_q[wr_ptr_q]  <= AW'(addr_ext);
			left_q[wr_ptr_q]  <= load_left;
			right_q[wr_ptr_q] <= load_right;
			env_q[wr_ptr_q]   <= envelope;
		end
	end

	assign head.valid = count_q != '0;
	assign head.kind  = kind_q[rd_ptr_q];
	assign head_addr  = addr_q[rd_ptr_q];
	assign head_left  = left_q[rd_ptr_q];
	assign head_right = right_q[rd_ptr_q];
	assign head_env   = env_q[rd_ptr_q];

endmodule

/* rtl/core/isp_lane.sv */
module isp_lane #(
	parameter int SAMPLE_DEPTH = 65536,
	parameter int SAMPLE_BITS  = 24,
	parameter int FRAC_BITS    = 16
) (
	input  logic                             clk,
	input  isp_pkg::lane_ctrl_t              ctrl,
	input  logic [$clog2(SAMPLE_DEPTH)-1:0]  addr,
	input  logic signed [SAMPLE_BITS-1:0]    wdata,
	input  logic [FRAC_BITS-1:0]             frac,
	input  logic [isp_pkg::VE_W-1:0]         ve,
	input  logic [isp_pkg::GAIN_W-1:0]       gain,
	output logic                             div_done,
	output logic signed [SAMPLE_BITS-1:0]    y
);

	localparam int SB   = SAMPLE_BITS;
	localparam int MA_W = SB + 1;
	localparam int MB_W = (FRAC_BITS + 1 > isp_pkg::VE_W + 1) ? FRAC_BITS + 1
	                                                          : isp_pkg::VE_W + 1;
	localparam int P_W  = MA_W + MB_W;
	localparam int IS_W = SB + FRAC_BITS + 2;
	localparam int VX_W = SB + isp_pkg::VE_W + 2;
	localparam int U_W  = SB + isp_pkg::DIGIT_W;
	localparam int G_W  = SB + isp_pkg::GAIN_W + 1;

	localparam logic signed [IS_W-1:0] INT_HALF =
		{{(IS_W - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
	localparam logic signed [VX_W-1:0] VE_HALF_W = VX_W'(isp_pkg::VE_HALF);
	localparam logic signed [VX_W-1:0] DIV_BIAS  = VX_W'(isp_pkg::VE_DIV) << (SB - 1);
	localparam logic signed [G_W-1:0]  G_HALF    = G_W'(1 << (isp_pkg::GAIN_SHIFT - 1));
	localparam logic signed [G_W-1:0]  Y_MAX     = {{(G_W - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
	localparam logic signed [G_W-1:0]  Y_MIN     = {{(G_W - SB + 1){1'b1}}, {(SB - 1){1'b0}}};

	logic [SB-1:0]          rdata;
	logic signed [SB-1:0]   a_q, s_q, t_q;
	logic [U_W-1:0]         u_q;
	logic [SB:0]            qt_q;
	logic signed [G_W-1:0]  p_q;

	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [P_W-1:0]  prod;
	logic signed [IS_W-1:0] interp_acc;
	logic signed [VX_W-1:0] vel_acc;
	logic signed [VX_W-1:0] u_full;
	logic [U_W-1:0]         u_hi;
	logic [SB-1:0]          q_sum;
	logic signed [G_W-1:0]  g_round;

	isp_ram #(
		.WIDTH(SB),
		.DEPTH(SAMPLE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ctrl.wr_en),
		.waddr (addr),
		.wdata (wdata),
		.re    (ctrl.rd_en),
		.raddr (addr),
		.rdata (rdata)
	);

	// one multiplier shared by interpolation, velocity/envelope and gain
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (ctrl.do_interp) begin
			mul_a = MA_W'($signed(rdata)) - MA_W'(a_q);
			mul_b = MB_W'($signed({1'b0, frac}));
		end else if (ctrl.do_vel) begin
			mul_a = MA_W'(s_q);
			mul_b = MB_W'($signed({1'b0, ve}));
		end else if (ctrl.do_gain) begin
			mul_a = MA_W'(t_q);
			mul_b = MB_W'($signed({1'b0, gain}));
		end
	end

	assign prod = P_W'(mul_a) * P_W'(mul_b);

	// a*(1-f) + b*f  ==  a + (b-a)*f
	assign interp_acc = (IS_W'(a_q) <<< FRAC_BITS) + IS_W'(prod) + INT_HALF;
	assign vel_acc    = VX_W'(prod) + VE_HALF_W;
	// biased so the divide by 127 runs on a non-negative value
	assign u_full     = (vel_acc >>> isp_pkg::VE_SHIFT) + DIV_BIAS;

	// 128 = 127 + 1: u = 128h + l gives u/127 = h + (h + l)/127
	assign div_done = u_q < U_W'(isp_pkg::DIV_STOP);
	assign u_hi     = u_q >> isp_pkg::DIGIT_W;
	assign q_sum    = qt_q[SB-1:0] + SB'(u_q >= U_W'(isp_pkg::VE_DIV));

	always_ff @(posedge clk) begin
		if (ctrl.cap_a) begin
			a_q <= $signed(rdata);
		end
		if (ctrl.do_interp) begin
			s_q <= SB'(interp_acc >>> FRAC_BITS);
		end
		if (ctrl.do_vel) begin
			u_q  <= U_W'(u_full);
			qt_q <= '0;
		end else if (ctrl.div_step && !div_done) begin
			u_q  <= u_hi + U_W'(u_q[isp_pkg::DIGIT_W-1:0]);
			qt_q <= qt_q + (SB + 1)'(u_hi);
		end
		if (ctrl.do_fix) begin
			// remove the bias: subtracting 2^(SB-1) flips the top bit
			t_q <= {~q_sum[SB-1], q_sum[SB-2:0]};
		end
		if (ctrl.do_gain) begin
			p_q <= G_W'(prod);
		end
	end

	assign g_round = (p_q + G_HALF) >>> isp_pkg::GAIN_SHIFT;

	always_comb begin
		if (g_round > Y_MAX) begin
			y = SB'(Y_MAX);
		end else if (g_round < Y_MIN) begin
			y = SB'(Y_MIN);
		end else begin
			y = SB'(g_round);
		end
	end

endmodule

/* rtl/core/isp_back.sv */
module isp_back #(
	parameter int SAMPLE_DEPTH = 65536,
	parameter int SAMPLE_BITS  = 24,
	parameter int FRAC_BITS    = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [isp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [isp_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  isp_pkg::q_head_t                     head,
	input  logic [$clog2(SAMPLE_DEPTH)-1:0]      head_addr,
	input  logic signed [SAMPLE_BITS-1:0]        head_left,
	input  logic signed [SAMPLE_BITS-1:0]        head_right,
	input  logic [isp_pkg::ENV_W-1:0]            head_env,
	output logic                                 pop,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [SAMPLE_BITS-1:0]        out_left,
	output logic signed [SAMPLE_BITS-1:0]        out_right
);

	localparam int AW     = $clog2(SAMPLE_DEPTH);
	localparam int LEN_W  = AW + 1;
	localparam int POS_W  = isp_pkg::POS_W;
	localparam int IW     = POS_W - FRAC_BITS;
	localparam int CNT_W  = $clog2(IW + 1);
	localparam int SPAN_W = LEN_W + FRAC_BITS;
	localparam int WIDE_W = (SPAN_W > POS_W + 1) ? SPAN_W : POS_W + 1;

	typedef enum logic [9:0] {
		S_IDLE = 10'b00_0000_0001,
		S_MOD  = 10'b00_0000_0010,
		S_RDA  = 10'b00_0000_0100,
		S_RDB  = 10'b00_0000_1000,
		S_INT  = 10'b00_0001_0000,
		S_VEL  = 10'b00_0010_0000,
		S_DIV  = 10'b00_0100_0000,
		S_FIX  = 10'b00_1000_0000,
		S_GAIN = 10'b01_0000_0000,
		S_OUT  = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	logic [isp_pkg::STEP_W-1:0]    step_q;
	logic [isp_pkg::LEN_REG_W-1:0] length_q;
	logic [isp_pkg::VEL_W-1:0]     vel_q;
	logic [isp_pkg::GAIN_W-1:0]    gain_q;
	logic [POS_W-1:0]              pos_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_left_q, out_right_q;

	logic [LEN_W-1:0]         len_q;
	logic [FRAC_BITS-1:0]     frac_q;
	logic [POS_W:0]           sum_q;
	logic [isp_pkg::VE_W-1:0] ve_q;
	logic [AW-1:0]            li_q, rem_q;
	logic [IW-1:0]            bits_q;
	logic [CNT_W-1:0]         cnt_q;

	logic [isp_pkg::CMP_W-1:0] len_ext, len_clamp;
	logic [LEN_W-1:0]          len_w;
	logic [IW-1:0]             ip;
	logic                      ip_fits;
	logic                      tick_go;
	logic [LEN_W-1:0]          t_mod;
	logic [AW-1:0]             rem_nxt;
	logic [LEN_W-1:0]          li_inc;
	logic [AW-1:0]             ri;
	logic [WIDE_W-1:0]         sum_w, span_w;
	logic [POS_W-1:0]          pos_wrap;
	logic                      out_load;
	logic                      done_l, done_r;
	logic signed [SAMPLE_BITS-1:0] y_l, y_r;

	isp_pkg::lane_ctrl_t ctrl;
	logic [AW-1:0]       lane_addr;

	// a length of zero plays one sample; beyond the store it is capped
	assign len_ext   = isp_pkg::CMP_W'(length_q);
	assign len_clamp = (len_ext == '0) ? isp_pkg::CMP_W'(1) :
	                   (len_ext > isp_pkg::CMP_W'(SAMPLE_DEPTH)) ?
	                   isp_pkg::CMP_W'(SAMPLE_DEPTH) : len_ext;
	assign len_w     = LEN_W'(len_clamp);

	assign ip      = pos_q[POS_W-1:FRAC_BITS];
	assign ip_fits = POS_W'(ip) < POS_W'(len_w);
	assign tick_go = state_q == S_IDLE && head.valid && head.kind == isp_pkg::CMD_TICK;

	// restoring remainder, one bit a cycle, for a position past the loop
	assign t_mod   = {rem_q, bits_q[IW-1]};
	assign rem_nxt = (t_mod >= len_q) ? AW'(t_mod - len_q) : AW'(t_mod);

	assign li_inc = LEN_W'(li_q) + 1'b1;
	assign ri     = (li_inc >= len_q) ? '0 : AW'(li_inc);

	assign sum_w    = WIDE_W'(sum_q);
	assign span_w   = WIDE_W'(len_q) << FRAC_BITS;
	assign pos_wrap = POS_W'((sum_w >= span_w) ? sum_w - span_w : sum_w);

	assign out_load = state_q == S_OUT && (!out_valid_q || !out_stall);

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		ctrl      = '0;
		lane_addr = li_q;
		case (state_q)
			S_IDLE: begin
				lane_addr = head_addr;
				if (head.valid) begin
					pop = 1'b1;
					case (head.kind)
						isp_pkg::CMD_LOAD: ctrl.wr_en = 1'b1;
						isp_pkg::CMD_TICK: state_d = ip_fits ? S_RDA : S_MOD;
						default: ;
					endcase
				end
			end
			S_MOD: begin
				if (cnt_q == CNT_W'(1)) begin
					state_d = S_RDA;
				end
			end
			S_RDA: begin
				ctrl.rd_en = 1'b1;
				state_d    = S_RDB;
			end
			S_RDB: begin
				lane_addr  = ri;
				ctrl.rd_en = 1'b1;
				ctrl.cap_a = 1'b1;
				state_d    = S_INT;
			end
			S_INT: begin
				ctrl.do_interp = 1'b1;
				state_d        = S_VEL;
			end
			S_VEL: begin
				ctrl.do_vel = 1'b1;
				state_d     = S_DIV;
			end
			S_DIV: begin
				ctrl.div_step = 1'b1;
				if (done_l && done_r) begin
					state_d = S_FIX;
				end
			end
			S_FIX: begin
				ctrl.do_fix = 1'b1;
				state_d     = S_GAIN;
			end
			S_GAIN: begin
				ctrl.do_gain = 1'b1;
				state_d      = S_OUT;
			end
			S_OUT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= isp_pkg::RST_STEP;
			length_q    <= isp_pkg::RST_LEN;
			vel_q       <= isp_pkg::RST_VEL;
			gain_q      <= isp_pkg::RST_GAIN;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (isp_pkg::reg_idx_t'(cfg_index))
					isp_pkg::REG_STEP:   step_q   <= cfg_data[isp_pkg::STEP_W-1:0];
					isp_pkg::REG_LENGTH: length_q <= cfg_data[isp_pkg::LEN_REG_W-1:0];
					isp_pkg::REG_VEL:    vel_q    <= cfg_data[isp_pkg::VEL_W-1:0];
					isp_pkg::REG_GAIN:   gain_q   <= cfg_data[isp_pkg::GAIN_W-1:0];
					default: ;
				endcase
			end
			if (state_q == S_IDLE && head.valid && head.kind == isp_pkg::CMD_RESTART) begin
				pos_q <= '0;
			end else if (state_q == S_RDA) begin
				pos_q <= pos_wrap;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_go) begin
			len_q  <= len_w;
			frac_q <= pos_q[FRAC_BITS-1:0];
			sum_q  <= (POS_W + 1)'(pos_q) + (POS_W + 1)'(step_q);
			ve_q   <= isp_pkg::VE_W'(vel_q) * isp_pkg::VE_W'(head_env);
			li_q   <= AW'(ip);
			rem_q  <= '0;
			bits_q <= ip;
			cnt_q  <= CNT_W'(IW);
		end else if (state_q == S_MOD) begin
			rem_q  <= rem_nxt;
			bits_q <= bits_q << 1;
			cnt_q  <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				li_q <= rem_nxt;
			end
		end
		if (out_load) begin
			out_left_q  <= y_l;
			out_right_q <= y_r;
		end
	end

	isp_lane #(
		.SAMPLE_DEPTH(SAMPLE_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_lane_l (
		.clk      (clk),
		.ctrl     (ctrl),
		.addr     (lane_addr),
		.wdata    (head_left),
		.frac     (frac_q),
		.ve       (ve_q),
		.gain     (gain_q),
		.div_done (done_l),
		.y        (y_l)
	);

	isp_lane #(
		.SAMPLE_DEPTH(SAMPLE_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_lane_r (
		.clk      (clk),
		.ctrl     (ctrl),
		.addr     (lane_addr),
		.wdata    (head_right),
		.frac     (frac_q),
		.ve       (ve_q),
		.gain     (gain_q),
		.div_done (done_r),
		.y        (y_r)
	);

	assign out_valid = out_valid_q;
	assign out_left  = out_left_q;
	assign out_right = out_right_q;

endmodule

/* rtl/core/interpolating_sample_player.sv */
// Looping stereo sample player with linear interpolation.
// Input channel (in_valid/in_stall): cmd selects load (writes load_left and
//   load_right at load_address), tick (one output beat, uses envelope) or
//   restart (play position back to zero). Other codes and loads beyond the
//   store are taken and dropped. A two-beat queue sits behind the port.
// Output channel (out_valid/out_stall): one beat per tick, held in an output
//   register; while it is stalled the queue still takes up to two beats.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): ready always;
//   write only with nothing in flight.
// Steps: load and restart are done in the back end's idle state. A tick
//   makes two reads of each channel store through its single port, uses
//   shared multiplier steps and a divide by 127 done one 7-bit digit a
//   cycle; a position past the loop length first runs a bit-serial
//   remainder.
// Reset: play position zero, registers to their defaults, queue and output
//   empty. Sample stores are not cleared; play only what has been loaded.
module interpolating_sample_player #(
	parameter int SAMPLE_DEPTH = 65536,
	parameter int SAMPLE_BITS  = 24,
	parameter int FRAC_BITS    = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [isp_pkg::CMD_W-1:0]      cmd,
	input  logic [isp_pkg::ADDR_IN_W-1:0]  load_address,
	input  logic signed [SAMPLE_BITS-1:0]  load_left,
	input  logic signed [SAMPLE_BITS-1:0]  load_right,
	input  logic [isp_pkg::ENV_W-1:0]      envelope,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_BITS-1:0]  out_left,
	output logic signed [SAMPLE_BITS-1:0]  out_right,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [isp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [isp_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = $clog2(SAMPLE_DEPTH);

	isp_pkg::q_head_t              head;
	logic [AW-1:0]                 head_addr;
	logic signed [SAMPLE_BITS-1:0] head_left, head_right;
	logic [isp_pkg::ENV_W-1:0]     head_env;
	logic                          pop;

	assign cfg_ready = 1'b1;

	isp_front #(
		.SAMPLE_DEPTH(SAMPLE_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.load_address (load_address),
		.load_left    (load_left),
		.load_right   (load_right),
		.envelope     (envelope),
		.head         (head),
		.head_addr    (head_addr),
		.head_left    (head_left),
		.head_right   (head_right),
		.head_env     (head_env),
		.pop          (pop)
	);

	isp_back #(
		.SAMPLE_DEPTH(SAMPLE_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.head       (head),
		.head_addr  (head_addr),
		.head_left  (head_left),
		.head_right (head_right),
		.head_env   (head_env),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_left   (out_left),
		.out_right  (out_right)
	);

endmodule

/* rtl/core/isp_checker.sv */
module isp_checker #(
	parameter int SAMPLE_BITS = 24
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [SAMPLE_BITS-1:0]  out_left,
	input logic [SAMPLE_BITS-1:0]  out_right
);

	// a stalled output beat stays up
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	// and keeps its samples
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_left) && $stable(out_right))
		else $error("output samples changed while stalled");

	// the queue only fills on a beat taken the cycle before
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall))
		else $error("input stall raised without a taken beat");

	// reset empties queue and output register
	assert property (@(posedge clk)
		!arst_n |-> !out_valid && !in_stall)
		else $error("queue or output not empty in reset");

endmodule

bind interpolating_sample_player isp_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_isp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_left  (out_left),
	.out_right (out_right)
);

/* tb/tb_interpolating_sample_player.sv */
module tb_interpolating_sample_player;
	timeunit 1ns;
	timeprecision 1ps;

	import isp_pkg::*;

	localparam int LIMIT = 1_000_000;
	localparam int RANDOM_ITEMS = 1450;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic signed [23:0] left;
		logic signed [23:0] right;
	} frame_t;

	class voice_scoreboard;
		logic [STEP_W-1:0] step;
		logic [LEN_REG_W-1:0] length;
		logic [VEL_W-1:0] vel;
		logic [GAIN_W-1:0] gain;
		logic [POS_W-1:0] pos;
		logic signed [23:0] left_mem [int];
		logic signed [23:0] right_mem [int];
		frame_t due_frames [$];
		int errors;

		function new();
			step = RST_STEP;
			length = RST_LEN;
			vel = RST_VEL;
			gain = RST_GAIN;
			pos = '0;
			errors = 0;
		endfunction

		function void configure(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_STEP: step = data[STEP_W-1:0];
				REG_LENGTH: length = data[LEN_REG_W-1:0];
				REG_VEL: vel = data[VEL_W-1:0];
				REG_GAIN: gain = data[GAIN_W-1:0];
			endcase
		endfunction

		function int loop_len();
			if (length == 0)
				return 1;
			if (length > 65536)
				return 65536;
			return int'(length);
		endfunction

		function void next_reads(output int li, output int ri);
			li = int'(pos >> 16) % loop_len();
			ri = (li + 1 >= loop_len()) ? 0 : li + 1;
		endfunction

		function bit holds(int idx);
			return left_mem.exists(idx);
		endfunction

		function int outstanding();
			return due_frames.size();
		endfunction

		function logic signed [23:0] voice_level(logic signed [23:0] a, logic signed [23:0] b,
				logic [15:0] frac, logic [15:0] env);
			longint ve_div, s, t, y;
			ve_div = 127 * 65536;
			s = (longint'(a) * (65536 - longint'(frac)) + longint'(b) * longint'(frac)
				+ 32768) >>> 16;
			t = s * longint'(vel) * longint'(env) + ve_div / 2;
			t = (t >= 0) ? t / ve_div : -((ve_div - 1 - t) / ve_div);
			y = (t * longint'(gain) + 32768) >>> 16;
			if (y > 8388607)
				y = 8388607;
			else if (y < -8388608)
				y = -8388608;
			return y[23:0];
		endfunction

		function void take_item(logic [CMD_W-1:0] c, logic [15:0] addr,
				logic signed [23:0] l, logic signed [23:0] r, logic [15:0] env);
			int li, ri;
			logic [32:0] nxt;
			logic [32:0] span;
			frame_t f;
			if (c == CMD_LOAD) begin
				left_mem[addr] = l;
				right_mem[addr] = r;
			end else if (c == CMD_RESTART) begin
				pos = '0;
			end else if (c == CMD_TICK) begin
				next_reads(li, ri);
				f.left = voice_level(left_mem[li], left_mem[ri], pos[15:0], env);
				f.right = voice_level(right_mem[li], right_mem[ri], pos[15:0], env);
				due_frames.push_back(f);
				span = 33'(loop_len()) << 16;
				nxt = 33'(pos) + 33'(step);
				if (nxt >= span)
					nxt = nxt - span;
				pos = nxt[31:0];
			end
		endfunction

		function void check_frame(logic signed [23:0] l, logic signed [23:0] r);
			frame_t f;
			if (due_frames.size() == 0) begin
				$error("output beat with no tick pending: left %0d right %0d", l, r);
				errors++;
				return;
			end
			f = due_frames.pop_front();
			if (l !== f.left) begin
				$error("out_left: expected %0d, got %0d", $signed(f.left), l);
				errors++;
			end
			if (r !== f.right) begin
				$error("out_right: expected %0d, got %0d", $signed(f.right), r);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [CMD_W-1:0] cmd;
	logic [ADDR_IN_W-1:0] load_address;
	logic signed [23:0] load_left;
	logic signed [23:0] load_right;
	logic [ENV_W-1:0] envelope;
	logic out_valid;
	logic out_stall;
	logic signed [23:0] out_left;
	logic signed [23:0] out_right;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	voice_scoreboard sb;
	int unsigned cycles = 0;
	bit src_quiet;
	bit sink_quiet;
	int hold_off;
	int items_sent;

	interpolating_sample_player dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.load_address(load_address),
		.load_left(load_left),
		.load_right(load_right),
		.envelope(envelope),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_left(out_left),
		.out_right(out_right),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : sink
		int stall_left;
		stall_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				sb.check_frame(out_left, out_right);
				stall_left = sink_quiet ? 0 : $urandom_range(0, 5);
			end
			@(negedge clk);
			if (hold_off > 0) begin
				stall_left += hold_off;
				hold_off = 0;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic logic signed [23:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_env();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_item(input logic [CMD_W-1:0] c, input logic [15:0] addr,
			input logic signed [23:0] l, input logic signed [23:0] r, input logic [15:0] env);
		int gap;
		gap = src_quiet ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		load_address <= addr;
		load_left <= l;
		load_right <= r;
		envelope <= env;
		do @(posedge clk); while (in_stall);
		sb.take_item(c, addr, l, r, env);
		if (c != CMD_UNUSED)
			items_sent++;
		@(negedge clk);
	endtask

	task automatic load_item(input logic [15:0] addr, input logic signed [23:0] l,
			input logic signed [23:0] r);
		send_item(CMD_LOAD, addr, l, r, 16'($urandom));
	endtask

	// both read indices are loaded before the tick goes out
	task automatic play_tick(input logic [15:0] env);
		int li, ri;
		sb.next_reads(li, ri);
		if (!sb.holds(li))
			load_item(16'(li), rand_sample(), rand_sample());
		if (!sb.holds(ri))
			load_item(16'(ri), rand_sample(), rand_sample());
		send_item(CMD_TICK, 16'($urandom), 24'($urandom), 24'($urandom), env);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0) @(negedge clk);
		repeat (32) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.configure(idx, data);
		@(negedge clk);
	endtask

	task automatic set_voice(input logic [23:0] s, input logic [23:0] n,
			input logic [23:0] v, input logic [23:0] g);
		drain();
		write_reg(REG_STEP, s);
		write_reg(REG_LENGTH, n);
		write_reg(REG_VEL, v);
		write_reg(REG_GAIN, g);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int n_items, r, phase;
		logic [23:0] step_data, len_data, vel_data, gain_data;
		sb = new();
		arst_n <= 1'b0;
		in_valid = 1'b0;
		cmd = CMD_LOAD;
		load_address = '0;
		load_left = '0;
		load_right = '0;
		envelope = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_STEP;
		cfg_data = '0;
		src_quiet = 1'b0;
		sink_quiet = 1'b0;
		hold_off = 0;
		items_sent = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		load_item(16'd0, 24'sh7FFFFF, 24'sh800000);
		load_item(16'd1, 24'sh800000, 24'sh7FFFFF);
		load_item(16'hFFFF, rand_sample(), rand_sample());
		play_tick(16'hFFFF);
		play_tick(16'h0000);
		send_item(CMD_UNUSED, 16'($urandom), rand_sample(), rand_sample(), 16'($urandom));
		send_item(CMD_RESTART, 16'($urandom), rand_sample(), rand_sample(), 16'($urandom));
		play_tick(16'h8000);

		// half steps over a two-sample loop, full gain to saturate
		set_voice(24'h008000, 24'd2, 24'd127, 24'h0FFFFF);
		send_item(CMD_RESTART, 16'($urandom), rand_sample(), rand_sample(), 16'($urandom));
		repeat (4) play_tick(16'hFFFF);

		// step far larger than the loop: position stays past its end
		set_voice(24'hFFFFFF, 24'd3, 24'd1, 24'h010000);
		repeat (3) play_tick(rand_env());

		// zero length acts as one
		set_voice(24'd0, 24'd0, 24'd0, 24'd0);
		repeat (2) play_tick(rand_env());

		// oversized length acts as full depth
		set_voice(24'h012345, 24'h01FFFF, 24'd64, 24'h00FFFF);
		repeat (3) play_tick(rand_env());

		items_sent = 0;
		phase = 0;
		while (items_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: step_data = 24'd0;
				1: step_data = 24'hFFFFFF;
				2: step_data = 24'($urandom);
				default: step_data = 24'($urandom_range(0, 24'h03FFFF));
			endcase
			case ($urandom_range(0, 9))
				0: len_data = 24'd0;
				1: len_data = 24'd65536;
				2: len_data = 24'($urandom_range(65537, 131071));
				3: len_data = 24'd1;
				default: len_data = 24'($urandom_range(2, 48));
			endcase
			len_data[23:17] = 7'($urandom);
			case ($urandom_range(0, 5))
				0: vel_data = 24'd0;
				1: vel_data = 24'd127;
				default: vel_data = 24'($urandom_range(0, 127));
			endcase
			vel_data[23:7] = 17'($urandom);
			case ($urandom_range(0, 7))
				0: gain_data = 24'h0FFFFF;
				1: gain_data = 24'd0;
				default: gain_data = 24'($urandom_range(0, 24'h02FFFF));
			endcase
			gain_data[23:20] = 4'($urandom);
			set_voice(step_data, len_data, vel_data, gain_data);

			src_quiet = ($urandom_range(0, 3) == 0);
			sink_quiet = ($urandom_range(0, 3) == 0);
			if (phase == 2) begin
				// long output hold-off while input keeps coming
				src_quiet = 1'b1;
				sink_quiet = 1'b0;
				hold_off = 400;
			end
			n_items = $urandom_range(30, 110);
			repeat (n_items) begin
				r = $urandom_range(0, 99);
				if (r < 60)
					play_tick(rand_env());
				else if (r < 70)
					load_item(16'($urandom_range(0, sb.loop_len() - 1)), rand_sample(),
						rand_sample());
				else if (r < 80)
					load_item(16'($urandom), rand_sample(), rand_sample());
				else if (r < 88)
					send_item(CMD_RESTART, 16'($urandom), rand_sample(), rand_sample(),
						16'($urandom));
				else if (r < 93)
					send_item(CMD_UNUSED, 16'($urandom), rand_sample(), rand_sample(),
						16'($urandom));
				else
					play_tick(16'hFFFF);
			end
			phase++;
		end

		drain();
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
